### rtl/bmhq_pkg.sv
// Shared types, constants and helper functions of the binary min-heap queue.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int VALUE_W  = 32;
  localparam int OUT_CNT_W = 11;

  // One cell per heap level; node numbers are 1-based.
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int LEVELS  = COUNT_W;
  localparam int OFS_W   = LEVELS - 1;
  localparam int ROW_W   = (LEVELS > 2) ? LEVELS - 2 : 1;
  localparam int PATH_W  = LEVELS - 1;
  localparam int REM_W   = $clog2(LEVELS);
  localparam int NODE_W  = COUNT_W + 2;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [2*VALUE_W-1:0]      row_t;

  // Wave that walks down the chain. For insert, ofs is the node's place in its
  // level; for sift-down, ofs is the parent's place and node its number.
  typedef struct packed {
    logic               valid;
    logic               sift;
    value_t             value;
    logic [OFS_W-1:0]   ofs;
    logic [COUNT_W-1:0] node;
    logic [PATH_W-1:0]  path;
    logic [REM_W-1:0]   rem;
  } bmhq_tok_t;

  // Value handed back up to fill the parent slot.
  typedef struct packed {
    logic   valid;
    value_t value;
  } bmhq_wb_t;

  // Direct read of one slot, issued by the controller.
  typedef struct packed {
    logic             valid;
    logic [OFS_W-1:0] ofs;
  } bmhq_fetch_t;

  function automatic logic less_than(input value_t a, input value_t b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [OFS_W-1:0] ofs);
    logic [OFS_W-1:0] s;
    s = ofs >> 1;
    return s[ROW_W-1:0];
  endfunction

  function automatic value_t get_half(input row_t row, input logic half);
    return half ? value_t'(row[2*VALUE_W-1:VALUE_W]) : value_t'(row[VALUE_W-1:0]);
  endfunction

  function automatic row_t put_half(input row_t row, input logic half, input value_t v);
    row_t r;
    r = row;
    if (half) begin
      r[2*VALUE_W-1:VALUE_W] = v;
    end else begin
      r[VALUE_W-1:0] = v;
    end
    return r;
  endfunction

  function automatic logic [REM_W-1:0] msb_index(input logic [COUNT_W-1:0] n);
    logic [REM_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < COUNT_W; i++) begin
      if (n[i]) begin
        idx = REM_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### rtl/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue: controller, level cells and memories.
//
// Use: a command beat (opcode, item_value) enters on cmd_valid/cmd_stall; each command
// returns exactly one result beat (min_value, status, entry_count) on res_valid/res_stall.
// Insert adds a signed value, extract returns and removes the least value, peek returns
// it and leaves the heap alone. A full heap drops an insert with status full; an empty
// heap answers extract or peek with status empty; both give min_value zero.
// Commands run one at a time. The heap is a chain of one cell per level, each cell with
// its own level memory; a wave walks down the chain, at each level first reading the
// memory, then comparing and writing back.
// The result beat is presented in the first cycle in which the next command may be taken.
// Reset empties the heap at once; the level memories need no clearing pass, as only
// slots below the entry count are ever read. cmd_stall is high while a command runs.
// A stalled result beat holds; the next command may still run and waits for the
// output register only when its own result is ready.
`default_nettype none

module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire logic [1:0]           opcode,
  input  wire logic [VALUE_W-1:0]   item_value,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic      [VALUE_W-1:0]   min_value,
  output logic      [1:0]           status,
  output logic      [OUT_CNT_W-1:0] entry_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_SETTLE = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]         state;
  logic [COUNT_W-1:0] count;
  logic [1:0]         op_q;
  logic [REM_W-1:0]   depth_q;
  logic [OFS_W-1:0]   last_ofs_q;
  value_t             res_q;
  logic [1:0]         st_q;
  bmhq_tok_t          ins_tok;
  bmhq_tok_t          sift_tok;

  logic               cmd_take;
  logic               res_load;
  logic [COUNT_W-1:0] acc_node;
  logic [REM_W-1:0]   acc_depth;
  logic [PATH_W-1:0]  acc_path;
  logic [COUNT_W-1:0] acc_ofs;

  bmhq_tok_t        tok_link   [LEVELS+1];
  bmhq_tok_t        cell_in    [LEVELS];
  bmhq_wb_t         wb_up      [LEVELS+1];
  bmhq_fetch_t      fetch_bus  [LEVELS];
  value_t           fetch_val  [LEVELS];
  logic             ram_re     [LEVELS];
  logic             ram_we     [LEVELS];
  logic [ROW_W-1:0] ram_addr   [LEVELS];
  row_t             ram_wdata  [LEVELS];
  row_t             ram_rdata  [LEVELS];
  logic [LEVELS-1:0] done_vec;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Load the output register when the result is ready and the register is free.
  assign res_load  = (state == S_FINISH) && (!res_valid || !res_stall);

  // Locate the node the command works on: the new slot for insert, the last for extract.
  assign acc_node  = (opcode == OP_INSERT) ? count + COUNT_W'(1) : count;
  assign acc_depth = msb_index(acc_node);
  assign acc_path  = PATH_W'(acc_node << (PATH_W - int'(acc_depth)));
  assign acc_ofs   = acc_node & ~(COUNT_W'(1) << acc_depth);

  // Level 0 takes insert waves; level 1 also takes the sift-down wave from the controller.
  assign tok_link[0]    = ins_tok;
  assign wb_up[LEVELS]  = '0;

  generate
    for (genvar k = 0; k < LEVELS; k++) begin : g_level
      localparam int DEPTH_K = (k == 0) ? 1 : (1 << (k - 1));
      localparam int AW_K    = (DEPTH_K > 1) ? $clog2(DEPTH_K) : 1;

      if (k == 1) begin : g_merge
        assign cell_in[k] = sift_tok.valid ? sift_tok : tok_link[k];
      end else begin : g_plain
        assign cell_in[k] = tok_link[k];
      end

      always_comb begin
        fetch_bus[k].valid = (state == S_FETCH) &&
                             ((k == 0) || ((op_q == OP_EXTRACT) && (int'(depth_q) == k)));
        fetch_bus[k].ofs   = (k == 0) ? '0 : last_ofs_q;
      end

      bmhq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .tok_in     (cell_in[k]),
        .tok_out    (tok_link[k+1]),
        .wb_in      (wb_up[k+1]),
        .wb_out     (wb_up[k]),
        .fetch      (fetch_bus[k]),
        .count      (count),
        .ram_re     (ram_re[k]),
        .ram_we     (ram_we[k]),
        .ram_addr   (ram_addr[k]),
        .ram_wdata  (ram_wdata[k]),
        .ram_rdata  (ram_rdata[k]),
        .fetch_value(fetch_val[k]),
        .done       (done_vec[k])
      );

      bmhq_ram #(
        .WIDTH(2 * VALUE_W),
        .DEPTH(DEPTH_K)
      ) u_ram (
        .clk  (clk),
        .we   (ram_we[k]),
        .re   (ram_re[k]),
        .addr (ram_addr[k][AW_K-1:0]),
        .wdata(ram_wdata[k]),
        .rdata(ram_rdata[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ins_tok   <= '0;
      sift_tok  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            op_q       <= opcode;
            depth_q    <= acc_depth;
            last_ofs_q <= OFS_W'(acc_ofs);
            res_q      <= '0;
            unique case (opcode) inside
              OP_INSERT: begin
                if (count >= COUNT_W'(CAPACITY)) begin
                  st_q  <= ST_FULL;
                  state <= S_FINISH;
                end else begin
                  st_q          <= ST_OK;
                  count         <= count + COUNT_W'(1);
                  ins_tok.valid <= 1'b1;
                  ins_tok.sift  <= 1'b0;
                  ins_tok.value <= value_t'(item_value);
                  ins_tok.ofs   <= '0;
                  ins_tok.node  <= '0;
                  ins_tok.path  <= acc_path;
                  ins_tok.rem   <= acc_depth;
                  state         <= S_RUN;
                end
              end
              OP_EXTRACT, OP_PEEK: begin
                if (count == '0) begin
                  st_q  <= ST_EMPTY;
                  state <= S_FINISH;
                end else begin
                  st_q  <= ST_OK;
                  state <= S_FETCH;
                end
              end
              default: begin
                st_q  <= ST_OK;
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_SETTLE;
        end
        S_SETTLE: begin
          // The root, and for extract the last entry, are now in the read registers of their cells.
          res_q <= fetch_val[0];
          if (op_q == OP_EXTRACT) begin
            count <= count - COUNT_W'(1);
            if (count == COUNT_W'(1)) begin
              state <= S_FINISH;
            end else begin
              sift_tok.valid <= 1'b1;
              sift_tok.sift  <= 1'b1;
              sift_tok.value <= fetch_val[depth_q];
              sift_tok.ofs   <= '0;
              sift_tok.node  <= COUNT_W'(1);
              sift_tok.path  <= '0;
              sift_tok.rem   <= '0;
              state          <= S_RUN;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_RUN: begin
          // A wave enters the chain for one cycle only.
          ins_tok.valid  <= 1'b0;
          sift_tok.valid <= 1'b0;
          if (|done_vec) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold the result until the output register is free.
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Raise the result beat on a load; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      min_value   <= res_q;
      status      <= st_q;
      entry_count <= OUT_CNT_W'(count);
    end
  end

  // A wave never runs past the deepest level: an insert stops at its own level, a sift-down where no grandchild exists.
  a_no_wave_past_bottom: assert property (@(posedge clk) disable iff (rst)
    !tok_link[LEVELS].valid)
    else $error("wave left the deepest level");

  // The root has no parent to fill.
  a_no_fill_above_root: assert property (@(posedge clk) disable iff (rst)
    !wb_up[0].valid)
    else $error("fill request above the root");

  // A wave ends in at most one level at a time, and only while the controller waits for it.
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0(done_vec) && ((done_vec == '0) || (state == S_RUN)))
    else $error("command ended in several levels or outside the run state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

endmodule

`default_nettype wire

### rtl/bmhq_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/bmhq_cell.sv
// One heap level: read, compare and write back the rows of its level memory.
`default_nettype none

module bmhq_cell
  import bmhq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bmhq_tok_t          tok_in,
  output bmhq_tok_t               tok_out,
  input  wire bmhq_wb_t           wb_in,
  output bmhq_wb_t                wb_out,
  input  wire bmhq_fetch_t        fetch,
  input  wire logic [COUNT_W-1:0] count,
  output logic                    ram_re,
  output logic                    ram_we,
  output logic      [ROW_W-1:0]   ram_addr,
  output row_t                    ram_wdata,
  input  wire row_t               ram_rdata,
  output value_t                  fetch_value,
  output logic                    done
);

  bmhq_tok_t        stage;
  bmhq_tok_t        tok_next;
  logic [OFS_W-1:0] hold_ofs;
  logic [OFS_W-1:0] hold_ofs_next;

  logic [ROW_W-1:0]  raddr;
  logic [ROW_W-1:0]  waddr;
  value_t            lo;
  value_t            hi;
  value_t            old;
  value_t            cbest;
  logic [NODE_W-1:0] lnode;
  logic [NODE_W-1:0] cnode;
  logic [NODE_W-1:0] cnt_w;
  logic              lv;
  logic              rv;
  logic              take_r;
  logic              child_wins;
  logic              grand;
  logic [OFS_W-1:0]  new_ofs;

  assign ram_re = tok_in.valid || fetch.valid;

  always_comb begin
    if (tok_in.valid) begin
      raddr = tok_in.sift ? tok_in.ofs[ROW_W-1:0] : row_of(tok_in.ofs);
    end else begin
      raddr = row_of(fetch.ofs);
    end
  end

  assign ram_addr    = ram_we ? waddr : raddr;
  assign fetch_value = get_half(ram_rdata, hold_ofs[0]);

  always_comb begin
    lo         = get_half(ram_rdata, 1'b0);
    hi         = get_half(ram_rdata, 1'b1);
    old        = get_half(ram_rdata, stage.ofs[0]);
    cnt_w      = NODE_W'(count);
    lnode      = NODE_W'(stage.node) << 1;
    lv         = lnode <= cnt_w;
    rv         = (lnode + NODE_W'(1)) <= cnt_w;
    take_r     = rv && less_than(hi, lo);
    cbest      = take_r ? hi : lo;
    child_wins = lv && less_than(cbest, stage.value);
    cnode      = lnode + NODE_W'(take_r);
    grand      = (cnode << 1) <= cnt_w;
    new_ofs    = (stage.ofs << 1) | OFS_W'(take_r);

    ram_we        = 1'b0;
    ram_wdata     = ram_rdata;
    waddr         = row_of(hold_ofs);
    done          = 1'b0;
    wb_out        = '0;
    tok_next      = '0;
    hold_ofs_next = hold_ofs;

    // Fill the slot this cell holds with the value the level below sent up.
    if (wb_in.valid) begin
      ram_we    = 1'b1;
      ram_wdata = put_half(ram_rdata, hold_ofs[0], wb_in.value);
    end

    if (stage.valid && !stage.sift) begin
      // Insert: keep the smaller value on the path, pass the larger down.
      waddr = row_of(stage.ofs);
      if (stage.rem == '0) begin
        ram_we    = 1'b1;
        ram_wdata = put_half(ram_rdata, stage.ofs[0], stage.value);
        done      = 1'b1;
      end else begin
        tok_next.valid = 1'b1;
        tok_next.sift  = 1'b0;
        tok_next.ofs   = (stage.ofs << 1) | OFS_W'(stage.path[PATH_W-1]);
        tok_next.path  = stage.path << 1;
        tok_next.rem   = stage.rem - REM_W'(1);
        if (less_than(stage.value, old)) begin
          ram_we         = 1'b1;
          ram_wdata      = put_half(ram_rdata, stage.ofs[0], stage.value);
          tok_next.value = old;
        end else begin
          tok_next.value = stage.value;
        end
      end
    end

    if (stage.valid && stage.sift) begin
      // Sift-down: the children of the parent sit in the row just read.
      waddr        = stage.ofs[ROW_W-1:0];
      wb_out.valid = 1'b1;
      wb_out.value = child_wins ? cbest : stage.value;
      if (child_wins) begin
        if (grand) begin
          tok_next.valid = 1'b1;
          tok_next.sift  = 1'b1;
          tok_next.value = stage.value;
          tok_next.ofs   = new_ofs;
          tok_next.node  = COUNT_W'(cnode);
          hold_ofs_next  = new_ofs;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = put_half(ram_rdata, take_r, stage.value);
          done      = 1'b1;
        end
      end else begin
        done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage   <= '0;
      tok_out <= '0;
    end else begin
      stage   <= tok_in;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch.valid) begin
      hold_ofs <= fetch.ofs;
    end else begin
      hold_ofs <= hold_ofs_next;
    end
  end

endmodule

`default_nettype wire

### dv/heap_checker.sv
// Scoreboard for the min-heap queue: mirrors the heap and checks every result beat.
module heap_checker
  import bmhq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire logic                 cmd_stall,
  input  wire logic [1:0]           opcode,
  input  wire logic [VALUE_W-1:0]   item_value,
  input  wire logic                 res_valid,
  input  wire logic                 res_stall,
  input  wire logic [VALUE_W-1:0]   min_value,
  input  wire logic [1:0]           status,
  input  wire logic [OUT_CNT_W-1:0] entry_count,
  output int                        error_count,
  output int                        answers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    value_t               value;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] count;
  } heap_answer_t;

  value_t       slots [CAPACITY];
  int           held;
  heap_answer_t answer_q [$];

  task automatic sift_up_from(input int pos);
    int     up;
    value_t t;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(slots[pos] < slots[up])) break;
      t = slots[pos];
      slots[pos] = slots[up];
      slots[up] = t;
      pos = up;
    end
  endtask

  // On a tie between the children keep the left one.
  task automatic sift_down_root();
    int     pos;
    int     lc;
    int     rc;
    int     best;
    value_t t;
    pos = 0;
    forever begin
      lc = 2 * pos + 1;
      rc = lc + 1;
      best = pos;
      if (lc < held && slots[lc] < slots[best]) best = lc;
      if (rc < held && slots[rc] < slots[best]) best = rc;
      if (best == pos) break;
      t = slots[pos];
      slots[pos] = slots[best];
      slots[best] = t;
      pos = best;
    end
  endtask

  task automatic heap_apply(input logic [1:0] op, input value_t v, output heap_answer_t a);
    a.value = '0;
    a.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          a.status = ST_FULL;
        end else begin
          slots[held] = v;
          held++;
          sift_up_from(held - 1);
        end
      end
      OP_EXTRACT: begin
        if (held == 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.value = slots[0];
          slots[0] = slots[held - 1];
          held--;
          if (held > 0) sift_down_root();
        end
      end
      OP_PEEK: begin
        if (held == 0) begin
          a.status = ST_EMPTY;
        end else begin
          a.value = slots[0];
        end
      end
      default: ;
    endcase
    a.count = OUT_CNT_W'(held);
  endtask

  always @(posedge clk) begin
    heap_answer_t fresh;
    heap_answer_t due;
    if (rst) begin
      held = 0;
      answer_q.delete();
      error_count = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        heap_apply(opcode, item_value, fresh);
        answer_q.push_back(fresh);
      end
      if (res_valid && !res_stall) begin
        if (answer_q.size() == 0) begin
          $error("result beat with no command waiting: min_value %0d status %0d count %0d",
                 $signed(min_value), status, entry_count);
          error_count++;
        end else begin
          due = answer_q.pop_front();
          if (min_value !== due.value) begin
            $error("min_value: expected %0d, actual %0d", due.value, $signed(min_value));
            error_count++;
          end
          if (status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, status);
            error_count++;
          end
          if (entry_count !== due.count) begin
            $error("entry_count: expected %0d, actual %0d", due.count, entry_count);
            error_count++;
          end
        end
      end
    end
    answers_due = answer_q.size();
  end

endmodule

### dv/tb_top.sv
// Test top for the min-heap queue: clock, reset, command stimulus, result stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  // Opcode the block must ignore; it has no name in the package.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Longest stretch with no beat on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 5000;
  // Slowest command plus margin; wait this long after the last result.
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_LONG_HOLD} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  logic [1:0]           opcode = OP_INSERT;
  logic [VALUE_W-1:0]   item_value = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [VALUE_W-1:0]   min_value;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] entry_count;

  int error_count;
  int answers_due;

  // Sender bookkeeping: beats left in the current burst, and entries the heap
  // should hold, used only to steer the stimulus toward full.
  int burst_left = 0;
  int fill_level = 0;

  always #5 clk = ~clk;

  binary_min_heap_queue dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .item_value  (item_value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .min_value   (min_value),
    .status      (status),
    .entry_count (entry_count)
  );

  heap_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .item_value  (item_value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .min_value   (min_value),
    .status      (status),
    .entry_count (entry_count),
    .error_count (error_count),
    .answers_due (answers_due)
  );

  // Present one command beat at the falling edge and hold it until taken.
  // When the burst runs out, drop valid for a random gap first.
  task automatic send_beat(input logic [1:0] op, input value_t val);
    @(negedge clk);
    if (burst_left == 0) begin
      cmd_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      // Mostly short bursts, now and then a long run with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    cmd_valid = 1'b1;
    opcode = op;
    item_value = val;
    do @(posedge clk); while (cmd_stall);
    burst_left--;
    case (op)
      OP_INSERT: if (fill_level < CAPACITY) fill_level++;
      OP_EXTRACT: if (fill_level > 0) fill_level--;
      default: ;
    endcase
  endtask

  // Mix of full-range values, a narrow band that forces ties, and the extremes.
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return value_t'($urandom());
      5, 6, 7: return value_t'(int'($urandom_range(0, 16)) - 8);
      8: return $urandom_range(0, 1) ? value_t'(32'h7fff_ffff) : value_t'(32'h8000_0000);
      default: return $urandom_range(0, 1) ? value_t'(32'h7fff_fff0 + $urandom_range(0, 15))
                                           : value_t'(32'h8000_0000 + $urandom_range(0, 15));
    endcase
  endfunction

  // Pick an opcode from percentage weights; what is left over goes to the unused code.
  function automatic logic [1:0] pick_op(input int ins_pct, input int ext_pct, input int peek_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return OP_INSERT;
    if (roll < ins_pct + ext_pct) return OP_EXTRACT;
    if (roll < ins_pct + ext_pct + peek_pct) return OP_PEEK;
    return OP_UNUSED;
  endfunction

  // Result side: switch between open, choppy and long-hold stall patterns.
  rx_mode_t rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: res_stall <= 1'b0;
      RX_CHOPPY: res_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          res_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(4, 40);
          res_stall <= 1'b1;
        end else begin
          res_stall <= 1'b0;
        end
      end
    endcase
  end

  // Watchdog: count cycles with no beat on either channel.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every opcode on an empty heap, the value extremes, ties,
    // then drain past empty.
    send_beat(OP_UNUSED, value_t'($urandom()));
    send_beat(OP_EXTRACT, value_t'($urandom()));
    send_beat(OP_PEEK, value_t'($urandom()));
    send_beat(OP_INSERT, value_t'(32'h7fff_ffff));
    send_beat(OP_PEEK, value_t'($urandom()));
    send_beat(OP_INSERT, value_t'(32'h8000_0000));
    send_beat(OP_INSERT, value_t'(0));
    send_beat(OP_INSERT, value_t'(-1));
    send_beat(OP_INSERT, value_t'(0));
    send_beat(OP_INSERT, value_t'(1));
    send_beat(OP_PEEK, value_t'($urandom()));
    send_beat(OP_UNUSED, value_t'(32'hffff_ffff));
    repeat (7) send_beat(OP_EXTRACT, value_t'($urandom()));
    // Equal entries: sift-down meets a child equal to the value it carries.
    repeat (3) send_beat(OP_INSERT, value_t'(5));
    repeat (3) send_beat(OP_EXTRACT, value_t'($urandom()));

    // Grow the heap to capacity with random content, churning as it goes,
    // so extracts sift down through every level.
    while (fill_level < CAPACITY) begin
      send_beat(pick_op(93, 4, 2), pick_value());
    end

    // Hover at the top: inserts into a full heap, extracts and refills.
    repeat (60) begin
      send_beat(pick_op(55, 35, 7), pick_value());
    end

    @(negedge clk);
    cmd_valid = 1'b0;
    while (answers_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
